@@ rtl/stlv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and record tables of the sensor TLV payload decoder.
package stlv_pkg;

    localparam int MAX_VALUES  = 4;
    localparam int START_LIMIT = 100;
    localparam int OFFSET_W    = 7;
    localparam int COUNT_W     = 3;
    localparam int POS_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    localparam logic [7:0] CH_TEMP     = 8'h01;
    localparam logic [7:0] CH_HUMID    = 8'h02;
    localparam logic [7:0] CH_BATT     = 8'h03;
    localparam logic [7:0] CH_STATUS   = 8'hff;
    localparam logic [7:0] TY_TEMP     = 8'h67;
    localparam logic [7:0] TY_HUMID    = 8'h68;
    localparam logic [7:0] TY_BATT     = 8'h75;
    localparam logic [7:0] TY_SKIP3_A  = 8'h0b;
    localparam logic [7:0] TY_SKIP3_B  = 8'h01;
    localparam logic [7:0] TY_SKIP8_A  = 8'h08;
    localparam logic [7:0] TY_SKIP8_B  = 8'h09;
    localparam logic [7:0] TY_DEV_TEMP = 8'h0d;

    localparam logic [POS_W-1:0] POS_CHANNEL = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE    = 4'd1;
    localparam logic [POS_W-1:0] POS_DATA    = 4'd2;
    localparam logic [POS_W-1:0] POS_HIGH    = 4'd3;
    localparam logic [POS_W-1:0] POS_DEV_LOW = 4'd7;
    localparam logic [POS_W-1:0] POS_DEV_HI  = 4'd8;

    typedef enum logic [1:0] {
        QTY_NONE  = 2'd0,
        QTY_TEMP  = 2'd1,
        QTY_HUMID = 2'd2,
        QTY_BATT  = 2'd3
    } t_quantity;

    typedef enum logic [2:0] {
        REC_NONE,
        REC_TEMP,
        REC_HUMID,
        REC_BATT,
        REC_SKIP3,
        REC_SKIP8,
        REC_DEV_TEMP
    } t_rec_kind;

    typedef struct packed {
        logic        got;
        t_quantity   qty;
        logic [15:0] reading;
        logic        last;
        logic        stopped;
    } t_event;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_rec_kind classify(logic [7:0] ch, logic [7:0] ty);
        t_rec_kind k;
        k = REC_NONE;
        if (ch == CH_TEMP && ty == TY_TEMP) begin
            k = REC_TEMP;
        end else if (ch == CH_HUMID && ty == TY_HUMID) begin
            k = REC_HUMID;
        end else if (ch == CH_BATT && ty == TY_BATT) begin
            k = REC_BATT;
        end else if (ch == CH_STATUS) begin
            if (ty == TY_SKIP3_A || ty == TY_SKIP3_B) begin
                k = REC_SKIP3;
            end else if (ty == TY_SKIP8_A || ty == TY_SKIP8_B) begin
                k = REC_SKIP8;
            end else if (ty == TY_DEV_TEMP) begin
                k = REC_DEV_TEMP;
            end
        end
        return k;
    endfunction

    function automatic logic [POS_W-1:0] rec_len(t_rec_kind k);
        logic [POS_W-1:0] len;
        case (k)
            REC_TEMP:     len = 4'd4;
            REC_HUMID:    len = 4'd3;
            REC_BATT:     len = 4'd3;
            REC_SKIP3:    len = 4'd3;
            REC_SKIP8:    len = 4'd8;
            REC_DEV_TEMP: len = 4'd9;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic t_quantity rec_qty(t_rec_kind k);
        t_quantity q;
        case (k)
            REC_TEMP:     q = QTY_TEMP;
            REC_HUMID:    q = QTY_HUMID;
            REC_BATT:     q = QTY_BATT;
            REC_DEV_TEMP: q = QTY_TEMP;
            default:      q = QTY_NONE;
        endcase
        return q;
    endfunction

endpackage

@@ rtl/stlv_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts payload bytes, tracks records and classifies each byte into events.
module stlv_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_frame_end,
    output logic                   o_push,
    output stlv_pkg::t_event       o_event
);

    logic [stlv_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [stlv_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                          r_stopped, n_stopped;
    logic [7:0]                    r_chan, n_chan;
    stlv_pkg::t_rec_kind           r_kind, n_kind;
    logic [7:0]                    r_low, n_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_pos     <= stlv_pkg::POS_CHANNEL;
            r_stopped <= 1'b0;
        end else begin
            r_offset  <= n_offset;
            r_pos     <= n_pos;
            r_stopped <= n_stopped;
        end
        r_chan <= n_chan;
        r_kind <= n_kind;
        r_low  <= n_low;
    end

    always_comb begin
        stlv_pkg::t_rec_kind         kind;
        logic [stlv_pkg::POS_W-1:0]  pos_inc;
        logic                        got;
        stlv_pkg::t_quantity         qty;
        logic [15:0]                 rd;

        n_offset  = r_offset;
        n_pos     = r_pos;
        n_stopped = r_stopped;
        n_chan    = r_chan;
        n_kind    = r_kind;
        n_low     = r_low;
        kind      = stlv_pkg::classify(r_chan, i_data_byte);
        pos_inc   = r_pos + 4'd1;
        got       = 1'b0;
        qty       = stlv_pkg::QTY_NONE;
        rd        = '0;

        if (i_fire) begin
            if (!r_stopped) begin
                if (r_pos == stlv_pkg::POS_CHANNEL) begin
                    if (!i_frame_end) begin
                        if (r_offset >= stlv_pkg::OFFSET_W'(stlv_pkg::START_LIMIT)) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_chan = i_data_byte;
                            n_pos  = stlv_pkg::POS_TYPE;
                        end
                    end
                end else if (r_pos == stlv_pkg::POS_TYPE) begin
                    if (kind == stlv_pkg::REC_NONE) begin
                        n_stopped = 1'b1;
                        n_pos     = stlv_pkg::POS_CHANNEL;
                    end else begin
                        n_kind = kind;
                        n_pos  = stlv_pkg::POS_DATA;
                        // A record cut off after its type byte completes with zeros.
                        if (i_frame_end) begin
                            qty = stlv_pkg::rec_qty(kind);
                            got = (qty != stlv_pkg::QTY_NONE);
                        end
                    end
                end else begin
                    case (r_kind)
                        stlv_pkg::REC_TEMP: begin
                            if (r_pos == stlv_pkg::POS_DATA) begin
                                n_low = i_data_byte;
                                got   = i_frame_end;
                                rd    = {8'h00, i_data_byte};
                            end else if (r_pos == stlv_pkg::POS_HIGH) begin
                                got = 1'b1;
                                rd  = {i_data_byte, r_low};
                            end
                        end
                        stlv_pkg::REC_HUMID, stlv_pkg::REC_BATT: begin
                            if (r_pos == stlv_pkg::POS_DATA) begin
                                got = 1'b1;
                                rd  = {8'h00, i_data_byte};
                            end
                        end
                        stlv_pkg::REC_DEV_TEMP: begin
                            if (r_pos == stlv_pkg::POS_DEV_LOW) begin
                                n_low = i_data_byte;
                                got   = i_frame_end;
                                rd    = {8'h00, i_data_byte};
                            end else if (r_pos == stlv_pkg::POS_DEV_HI) begin
                                got = 1'b1;
                                rd  = {i_data_byte, r_low};
                            end else begin
                                got = i_frame_end;
                            end
                        end
                        default: begin
                            got = 1'b0;
                        end
                    endcase
                    qty = stlv_pkg::rec_qty(r_kind);
                    if (pos_inc >= stlv_pkg::rec_len(r_kind)) begin
                        n_pos = stlv_pkg::POS_CHANNEL;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
            end

            if (r_offset != stlv_pkg::OFFSET_MAX) begin
                n_offset = r_offset + 1'b1;
            end

            if (i_frame_end) begin
                n_offset  = '0;
                n_pos     = stlv_pkg::POS_CHANNEL;
                n_stopped = 1'b0;
            end
        end

        if (!got) begin
            qty = stlv_pkg::QTY_NONE;
            rd  = '0;
        end

        o_push          = i_fire && (got || i_frame_end);
        o_event.got     = got;
        o_event.qty     = qty;
        o_event.reading = rd;
        o_event.last    = i_frame_end;
        o_event.stopped = n_stopped | (r_stopped & ~i_frame_end) | (i_frame_end & r_stopped)
                          | (i_frame_end & !r_stopped & (r_pos == stlv_pkg::POS_CHANNEL)
                             & 1'b0)
                          | (i_frame_end & !r_stopped & (r_pos == stlv_pkg::POS_TYPE)
                             & (kind == stlv_pkg::REC_NONE));
    end

endmodule

@@ rtl/stlv_queue.sv @@
`timescale 1ns / 1ps
// Short event queue between the front end and the back end.
module stlv_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  stlv_pkg::t_event         i_event,
    input  logic                     i_pop,
    output stlv_pkg::t_event         o_head,
    output stlv_pkg::t_queue_status  o_status
);

    stlv_pkg::t_event                r_slot [stlv_pkg::QUEUE_DEPTH];
    logic [stlv_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [stlv_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [stlv_pkg::QPTR_W:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_event;
        end
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == (stlv_pkg::QPTR_W+1)'(stlv_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

@@ rtl/stlv_back.sv @@
`timescale 1ns / 1ps
// Back end: applies the per-frame value limit and holds the result register.
module stlv_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  stlv_pkg::t_event         i_head,
    input  stlv_pkg::t_queue_status  i_status,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_quantity,
    output logic [15:0]              o_reading,
    output logic                     o_frame_done,
    output logic                     o_parse_stopped,
    output logic                     o_values_dropped
);

    logic [stlv_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_dropped, n_dropped;
    logic                         r_valid;
    logic [1:0]                   r_quantity;
    logic [15:0]                  r_reading;
    logic                         r_frame_done;
    logic                         r_parse_stopped;
    logic                         r_values_dropped;
    logic                         can_load;
    logic                         keep;
    logic                         emit;

    assign can_load = !r_valid || !i_stall;
    assign o_pop    = can_load && !i_status.empty;

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        keep      = i_head.got;
        if (o_pop && i_head.got) begin
            if (r_count < stlv_pkg::COUNT_W'(stlv_pkg::MAX_VALUES)) begin
                n_count = r_count + 1'b1;
            end else begin
                n_dropped = 1'b1;
                keep      = 1'b0;
            end
        end
        emit = o_pop && (keep || i_head.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop && i_head.last) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_dropped <= n_dropped;
            end
            if (can_load) begin
                r_valid <= emit;
            end
        end
        if (emit) begin
            r_quantity       <= keep ? i_head.qty : stlv_pkg::QTY_NONE;
            r_reading        <= keep ? i_head.reading : 16'h0000;
            r_frame_done     <= i_head.last;
            r_parse_stopped  <= i_head.stopped;
            r_values_dropped <= n_dropped;
        end
    end

    assign o_valid          = r_valid;
    assign o_quantity       = r_quantity;
    assign o_reading        = r_reading;
    assign o_frame_done     = r_frame_done;
    assign o_parse_stopped  = r_parse_stopped;
    assign o_values_dropped = r_values_dropped;

endmodule

@@ rtl/sensor_tlv_payload_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the sensor TLV payload decoder.
//
// The input channel carries one payload byte per transfer with a frame-end
// mark on the last byte of a frame. The output channel carries one result per
// transfer: a temperature, humidity or battery reading as soon as its record
// completes, at most four per frame, and one closing result on every frame
// end with the stop and drop flags of that frame.
// The block takes one byte per cycle while the input stall is low. The front
// end parses a byte in the cycle of its transfer and writes its event into a
// four-entry queue; the back end moves events from the queue into the
// output register.
// When the receiver stalls, the output register holds its result and events
// pile up in the queue; the input stall rises once the queue is full and
// falls as soon as one entry leaves it.
// After reset the queue is empty, no result is valid, and the parser waits
// for the first channel byte of a new frame.
module sensor_tlv_payload_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_quantity,
    output logic [15:0] o_reading,
    output logic        o_frame_done,
    output logic        o_parse_stopped,
    output logic        o_values_dropped
);

    logic                     fire;
    logic                     push;
    logic                     pop;
    stlv_pkg::t_event         front_event;
    stlv_pkg::t_event         head;
    stlv_pkg::t_queue_status  q_status;

    assign o_stall = q_status.full;
    assign fire    = i_valid && !q_status.full;

    stlv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_push      (push),
        .o_event     (front_event)
    );

    stlv_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_event  (front_event),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    stlv_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_status         (q_status),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_quantity       (o_quantity),
        .o_reading        (o_reading),
        .o_frame_done     (o_frame_done),
        .o_parse_stopped  (o_parse_stopped),
        .o_values_dropped (o_values_dropped)
    );

    a_value_or_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_done |-> o_quantity != 2'(stlv_pkg::QTY_NONE))
        else $error("Result without a value does not close a frame.");

    a_none_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_quantity == 2'(stlv_pkg::QTY_NONE) |-> o_reading == 16'h0000)
        else $error("Result without a quantity carries a nonzero reading.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid right after reset.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("Queue popped while empty.");

endmodule

@@ test/sensor_tlv_payload_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the sensor TLV payload decoder, with a reading tracker class.
class tlv_decode_tracker;
    typedef struct packed {
        stlv_pkg::t_quantity qty;
        logic [15:0]         value;
        logic                done;
        logic                stopped;
        logic                dropped;
    } t_reading;

    t_reading expected_readings[$];
    int errors;

    logic [6:0] offset;
    logic [3:0] pos;
    logic [7:0] chan;
    logic [7:0] kind_code;
    logic [7:0] low_hold;
    logic [2:0] count;
    logic       stopped;
    logic       dropped;

    function new();
        errors = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        offset    = '0;
        pos       = stlv_pkg::POS_CHANNEL;
        chan      = '0;
        kind_code = '0;
        low_hold  = '0;
        count     = '0;
        stopped   = 1'b0;
        dropped   = 1'b0;
    endfunction

    function logic [3:0] length_of(logic [7:0] ch, logic [7:0] ty);
        if (ch == stlv_pkg::CH_TEMP && ty == stlv_pkg::TY_TEMP) return 4'd4;
        if (ch == stlv_pkg::CH_HUMID && ty == stlv_pkg::TY_HUMID) return 4'd3;
        if (ch == stlv_pkg::CH_BATT && ty == stlv_pkg::TY_BATT) return 4'd3;
        if (ch == stlv_pkg::CH_STATUS) begin
            if (ty == stlv_pkg::TY_SKIP3_A || ty == stlv_pkg::TY_SKIP3_B) return 4'd3;
            if (ty == stlv_pkg::TY_SKIP8_A || ty == stlv_pkg::TY_SKIP8_B) return 4'd8;
            if (ty == stlv_pkg::TY_DEV_TEMP) return 4'd9;
        end
        return 4'd0;
    endfunction

    function bit take_data(logic [7:0] b, inout stlv_pkg::t_quantity q,
                           inout logic [15:0] v);
        logic [3:0] len;
        bit got;
        len = length_of(chan, kind_code);
        got = 1'b0;
        if (chan == stlv_pkg::CH_TEMP) begin
            if (pos == stlv_pkg::POS_DATA) begin
                low_hold = b;
            end else if (pos == stlv_pkg::POS_HIGH) begin
                q = stlv_pkg::QTY_TEMP;
                v = {b, low_hold};
                got = 1'b1;
            end
        end else if (chan == stlv_pkg::CH_HUMID) begin
            if (pos == stlv_pkg::POS_DATA) begin
                q = stlv_pkg::QTY_HUMID;
                v = {8'h00, b};
                got = 1'b1;
            end
        end else if (chan == stlv_pkg::CH_BATT) begin
            if (pos == stlv_pkg::POS_DATA) begin
                q = stlv_pkg::QTY_BATT;
                v = {8'h00, b};
                got = 1'b1;
            end
        end else if (kind_code == stlv_pkg::TY_DEV_TEMP) begin
            if (pos == stlv_pkg::POS_DEV_LOW) begin
                low_hold = b;
            end else if (pos == stlv_pkg::POS_DEV_HI) begin
                q = stlv_pkg::QTY_TEMP;
                v = {b, low_hold};
                got = 1'b1;
            end
        end
        if (len == 0 || int'(pos) + 1 >= int'(len)) begin
            pos = stlv_pkg::POS_CHANNEL;
        end else begin
            pos = pos + 4'd1;
        end
        return got;
    endfunction

    function bit take_byte(logic [7:0] b, inout stlv_pkg::t_quantity q,
                           inout logic [15:0] v);
        if (pos == stlv_pkg::POS_TYPE) begin
            if (length_of(chan, b) == 0) begin
                stopped = 1'b1;
                pos = stlv_pkg::POS_CHANNEL;
                return 1'b0;
            end
            kind_code = b;
            pos = stlv_pkg::POS_DATA;
            return 1'b0;
        end
        return take_data(b, q, v);
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
        stlv_pkg::t_quantity q;
        logic [15:0]         v;
        bit                  got;
        int                  guard;
        t_reading            r;
        q = stlv_pkg::QTY_NONE;
        v = '0;
        got = 1'b0;
        if (!stopped) begin
            if (pos == stlv_pkg::POS_CHANNEL) begin
                if (!is_last) begin
                    if (offset >= stlv_pkg::START_LIMIT) begin
                        stopped = 1'b1;
                    end else begin
                        chan = b;
                        pos = stlv_pkg::POS_TYPE;
                    end
                end
            end else begin
                got = take_byte(b, q, v);
                if (is_last) begin
                    guard = 0;
                    while (!stopped && pos != stlv_pkg::POS_CHANNEL && guard < 16) begin
                        if (take_byte(8'h00, q, v)) got = 1'b1;
                        guard++;
                    end
                end
            end
        end
        if (offset != stlv_pkg::OFFSET_MAX) offset = offset + 7'd1;
        if (got) begin
            if (count < stlv_pkg::MAX_VALUES) begin
                count = count + 3'd1;
            end else begin
                dropped = 1'b1;
                got = 1'b0;
            end
        end
        if (!got) begin
            q = stlv_pkg::QTY_NONE;
            v = '0;
        end
        if (got || is_last) begin
            r.qty     = q;
            r.value   = v;
            r.done    = is_last;
            r.stopped = stopped;
            r.dropped = dropped;
            expected_readings.push_back(r);
        end
        if (is_last) clear_frame();
    endfunction

    task report(string what);
        if (errors < 100) $display("mismatch: %s", what);
        errors++;
    endtask

    task check_reading(logic [1:0] q, logic [15:0] v, logic done, logic stp, logic drp);
        t_reading e;
        if (expected_readings.size() == 0) begin
            report($sformatf("unexpected result quantity %0d reading %h", q, v));
            return;
        end
        e = expected_readings.pop_front();
        if (q !== e.qty) report($sformatf("quantity %0d, expected %0d", q, e.qty));
        if (v !== e.value) report($sformatf("reading %h, expected %h", v, e.value));
        if (done !== e.done) report($sformatf("frame_done %b, expected %b", done, e.done));
        if (stp !== e.stopped) report($sformatf("parse_stopped %b, expected %b", stp, e.stopped));
        if (drp !== e.dropped) report($sformatf("values_dropped %b, expected %b", drp, e.dropped));
    endtask
endclass

module sensor_tlv_payload_decoder_top_tb;
    localparam int QUIET_LIMIT = 4000;

    typedef enum int {
        RK_TEMP,
        RK_HUMID,
        RK_BATT,
        RK_SKIP3,
        RK_SKIP8,
        RK_DEV_TEMP,
        RK_BAD
    } t_rec_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_quantity;
    logic [15:0] o_reading;
    logic        o_frame_done;
    logic        o_parse_stopped;
    logic        o_values_dropped;

    tlv_decode_tracker tracker;
    logic [7:0] frame_bytes[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    sensor_tlv_payload_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_quantity      (o_quantity),
        .o_reading       (o_reading),
        .o_frame_done    (o_frame_done),
        .o_parse_stopped (o_parse_stopped),
        .o_values_dropped(o_values_dropped)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                i_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_reading(o_quantity, o_reading, o_frame_done, o_parse_stopped,
                                  o_values_dropped);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_record(t_rec_pick k);
        case (k)
            RK_TEMP: begin
                frame_bytes.push_back(stlv_pkg::CH_TEMP);
                frame_bytes.push_back(stlv_pkg::TY_TEMP);
                repeat (2) frame_bytes.push_back(pick_data());
            end
            RK_HUMID: begin
                frame_bytes.push_back(stlv_pkg::CH_HUMID);
                frame_bytes.push_back(stlv_pkg::TY_HUMID);
                frame_bytes.push_back(pick_data());
            end
            RK_BATT: begin
                frame_bytes.push_back(stlv_pkg::CH_BATT);
                frame_bytes.push_back(stlv_pkg::TY_BATT);
                frame_bytes.push_back(pick_data());
            end
            RK_SKIP3: begin
                frame_bytes.push_back(stlv_pkg::CH_STATUS);
                frame_bytes.push_back($urandom_range(0, 1) ? stlv_pkg::TY_SKIP3_A
                                                           : stlv_pkg::TY_SKIP3_B);
                frame_bytes.push_back(pick_data());
            end
            RK_SKIP8: begin
                frame_bytes.push_back(stlv_pkg::CH_STATUS);
                frame_bytes.push_back($urandom_range(0, 1) ? stlv_pkg::TY_SKIP8_A
                                                           : stlv_pkg::TY_SKIP8_B);
                repeat (6) frame_bytes.push_back(pick_data());
            end
            RK_DEV_TEMP: begin
                frame_bytes.push_back(stlv_pkg::CH_STATUS);
                frame_bytes.push_back(stlv_pkg::TY_DEV_TEMP);
                repeat (7) frame_bytes.push_back(pick_data());
            end
            default: begin
                frame_bytes.push_back(8'($urandom_range(0, 255)));
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= is_last;
        do @(posedge i_clk); while (o_stall);
        tracker.note_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    task automatic send_long_frame();
        int target;
        target = $urandom_range(96, 135);
        while (frame_bytes.size() < target) push_record(t_rec_pick'($urandom_range(0, 5)));
        send_frame();
    endtask

    task automatic send_random_frame();
        int mode;
        int cut;
        mode = $urandom_range(0, 99);
        if (mode < 85) begin
            repeat ($urandom_range(1, 7)) push_record(t_rec_pick'($urandom_range(0, 5)));
            if (mode >= 75) begin
                cut = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
        end else if (mode < 93) begin
            repeat ($urandom_range(0, 4)) push_record(t_rec_pick'($urandom_range(0, 5)));
            push_record(RK_BAD);
            repeat ($urandom_range(0, 3)) push_record(t_rec_pick'($urandom_range(0, 5)));
        end else begin
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_frame();
    endtask

    initial begin
        tracker = new();
        send_idle_pct = 11;
        recv_idle_pct = 70;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        frame_bytes = '{stlv_pkg::CH_TEMP, stlv_pkg::TY_TEMP, 8'hff, 8'hff,
                        stlv_pkg::CH_HUMID, stlv_pkg::TY_HUMID, 8'h00,
                        stlv_pkg::CH_BATT, stlv_pkg::TY_BATT, 8'hff,
                        stlv_pkg::CH_HUMID, stlv_pkg::TY_HUMID, 8'h80,
                        stlv_pkg::CH_BATT, stlv_pkg::TY_BATT, 8'h00};
        send_frame();
        frame_bytes = '{stlv_pkg::CH_BATT};
        send_frame();
        frame_bytes = '{stlv_pkg::CH_TEMP, stlv_pkg::TY_TEMP, 8'h34};
        send_frame();
        frame_bytes = '{stlv_pkg::CH_HUMID, stlv_pkg::TY_BATT, 8'haa};
        send_frame();
        frame_bytes = '{stlv_pkg::CH_STATUS, stlv_pkg::TY_SKIP3_A, 8'h11,
                        stlv_pkg::CH_STATUS, stlv_pkg::TY_DEV_TEMP, 8'h01};
        send_frame();

        send_long_frame();
        while (bytes_sent < 380) send_random_frame();

        send_idle_pct = 70;
        recv_idle_pct = 11;
        send_long_frame();
        while (bytes_sent < 740) send_random_frame();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len = 200;
        send_long_frame();
        while (bytes_sent < 1100) send_random_frame();

        i_valid <= 1'b0;
        while (tracker.expected_readings.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
